[hw/rtl/lgrs_pkg.sv]
// ----------------------------------------------------------------------------
// lgrs_pkg: shared types and constants for the Life row stencil
// Column count, register widths, result word type and the column mask.
// ----------------------------------------------------------------------------
package lgrs_pkg;

  // grid geometry
  localparam int unsigned MAX_COLS = 64;
  localparam int unsigned COL_W    = 7;   // width of the cols_used register
  localparam logic [COL_W-1:0] COLS_RESET = COL_W'(MAX_COLS);

  // output queue geometry
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef logic [MAX_COLS-1:0] row_t;

  // one result word
  typedef struct packed {
    row_t cells;
    logic last;
  } res_word_t;

  // bits below the effective column count are set
  function automatic row_t col_mask(input logic [COL_W-1:0] cols);
    row_t m;
    for (int c = 0; c < MAX_COLS; c++) begin
      m[c] = (COL_W'(c) < cols);
    end
    return m;
  endfunction

endpackage

[hw/rtl/life_generation_row_stencil_core.sv]
// ----------------------------------------------------------------------------
// life_generation_row_stencil_core: one Life generation, row by row
// Streams grid rows in and next-generation rows out on a bounded grid.
// ----------------------------------------------------------------------------
// A row word is taken every cycle while the four-word result queue has room
// for two words; each row is worked out in the cycle it arrives, by 64 column
// lanes in parallel, so the sustained rate is one row per cycle. The result
// for a row leaves one row late; the row marked final releases two results
// (or one, for a single-row grid), the last flagged with last_of_grid_o.
// Cells outside the grid are dead and columns at or above cols_used read as
// dead. cols_used resets to 64 and is written through cfg_we_i/cfg_wdata_i.
module life_generation_row_stencil_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lgrs_pkg::COL_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [lgrs_pkg::MAX_COLS-1:0] row_cells_i,
  input  logic                         final_row_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [lgrs_pkg::MAX_COLS-1:0] next_row_cells_o,
  output logic                         last_of_grid_o
);
  import lgrs_pkg::*;

  logic [COL_W-1:0] cols_used_q;
  row_t             older_q, older_d;
  row_t             middle_q, middle_d;
  logic             held_q, held_d;
  row_t             mask;
  row_t             cur;
  logic             accept;
  row_t             res_a, res_b;
  row_t             b_above;
  logic             push0, push1;
  res_word_t        word0, word1, q_word;
  logic             room2;

  assign mask   = col_mask(cols_used_q);
  assign cur    = row_cells_i & mask;
  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = room2;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_used_q <= COLS_RESET;
    end else if (cfg_we_i) begin
      cols_used_q <= cfg_wdata_i;
    end
  end

  // held middle row, completed by the incoming row
  lgrs_row u_row_a (
    .above_i (older_q),
    .mid_i   (middle_q),
    .below_i (cur),
    .mask_i  (mask),
    .next_o  (res_a)
  );

  // incoming row closed off by the bottom edge
  assign b_above = held_q ? middle_q : '0;

  lgrs_row u_row_b (
    .above_i (b_above),
    .mid_i   (cur),
    .below_i ('0),
    .mask_i  (mask),
    .next_o  (res_b)
  );

  // result words in order
  always_comb begin
    push0 = accept && (held_q || final_row_i);
    push1 = accept && held_q && final_row_i;
    word0.cells = held_q ? res_a : res_b;
    word0.last  = !held_q;
    word1.cells = res_b;
    word1.last  = 1'b1;
  end

  // row history
  always_comb begin
    older_d  = older_q;
    middle_d = middle_q;
    held_d   = held_q;
    if (accept) begin
      if (final_row_i) begin
        older_d  = '0;
        middle_d = '0;
        held_d   = 1'b0;
      end else begin
        older_d  = held_q ? (middle_q & mask) : '0;
        middle_d = cur;
        held_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q  <= '0;
      middle_q <= '0;
      held_q   <= 1'b0;
    end else begin
      older_q  <= older_d;
      middle_q <= middle_d;
      held_q   <= held_d;
    end
  end

  // result queue
  lgrs_out_q u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (push0),
    .word0_i (word0),
    .push1_i (push1),
    .word1_i (word1),
    .room2_o (room2),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .word_o  (q_word)
  );

  assign next_row_cells_o = q_word.cells;
  assign last_of_grid_o   = q_word.last;

endmodule

[hw/rtl/lgrs_lane.sv]
// ----------------------------------------------------------------------------
// lgrs_lane: one cell of the Life rule
// Counts eight neighbours and applies survive-on-2-or-3, birth-on-3.
// ----------------------------------------------------------------------------
module lgrs_lane (
  input  logic [7:0] nbr_i,
  input  logic       alive_i,
  output logic       next_o
);
  import lgrs_pkg::*;

  logic [3:0] nbr_cnt;

  // neighbour count
  always_comb begin
    nbr_cnt = 4'd0;
    for (int k = 0; k < 8; k++) begin
      nbr_cnt = nbr_cnt + {3'd0, nbr_i[k]};
    end
  end

  // rule
  assign next_o = (nbr_cnt == 4'd3) || (alive_i && (nbr_cnt == 4'd2));

endmodule

[hw/rtl/lgrs_row.sv]
// ----------------------------------------------------------------------------
// lgrs_row: next generation of one row
// One lane per column works on its 3x3 window; the lane outputs are merged
// into the result row and masked to the active columns.
// ----------------------------------------------------------------------------
module lgrs_row (
  input  lgrs_pkg::row_t above_i,
  input  lgrs_pkg::row_t mid_i,
  input  lgrs_pkg::row_t below_i,
  input  lgrs_pkg::row_t mask_i,
  output lgrs_pkg::row_t next_o
);
  import lgrs_pkg::*;

  // rows padded with a dead cell on each side: no wrap-around
  logic [MAX_COLS+1:0] above_pad;
  logic [MAX_COLS+1:0] mid_pad;
  logic [MAX_COLS+1:0] below_pad;
  row_t                lane_next;

  assign above_pad = {1'b0, above_i & mask_i, 1'b0};
  assign mid_pad   = {1'b0, mid_i   & mask_i, 1'b0};
  assign below_pad = {1'b0, below_i & mask_i, 1'b0};

  // lanes, padded index c+1 is column c
  for (genvar c = 0; c < MAX_COLS; c++) begin : g_lane
    lgrs_lane u_lane (
      .nbr_i   ({above_pad[c+2:c], below_pad[c+2:c], mid_pad[c+2], mid_pad[c]}),
      .alive_i (mid_pad[c+1]),
      .next_o  (lane_next[c])
    );
  end

  // merge
  assign next_o = lane_next & mask_i;

endmodule

[hw/rtl/lgrs_out_q.sv]
// ----------------------------------------------------------------------------
// lgrs_out_q: result queue
// Takes up to two words per cycle, hands out one word per cycle while ready_i is high.
// ----------------------------------------------------------------------------
module lgrs_out_q (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push0_i,
  input  lgrs_pkg::res_word_t word0_i,
  input  logic                push1_i,
  input  lgrs_pkg::res_word_t word1_i,
  output logic                room2_o,
  output logic                valid_o,
  input  logic                ready_i,
  output lgrs_pkg::res_word_t word_o
);
  import lgrs_pkg::*;

  res_word_t             mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0]    count_q, count_d;
  logic                  pop;
  logic [Q_CNT_W-1:0]    n_push;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  assign room2_o = (count_q <= Q_CNT_W'(Q_DEPTH - 2));
  assign word_o  = mem_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    n_push   = Q_CNT_W'(push0_i) + Q_CNT_W'(push1_i);
    wr_ptr_d = wr_ptr_q + Q_PTR_W'(n_push);
    rd_ptr_d = rd_ptr_q + Q_PTR_W'(pop);
    count_d  = count_q + n_push - Q_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage; word1 only ever comes with word0
  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      mem_q[wr_ptr_q] <= word0_i;
    end
    if (push1_i) begin
      mem_q[wr_ptr_q + Q_PTR_W'(1)] <= word1_i;
    end
  end

endmodule
